// ===== rtl/core/blss_pkg.sv =====
// ----------------------------------------------------------------------------
// blss_pkg
// Shared sizes, operation and status codes, and the bundles that pass between
// the control engine and the top level of the bounded stack.
// ----------------------------------------------------------------------------
package blss_pkg;

	// storage geometry
	localparam int DEPTH  = 256;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int WORD_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 8;
	localparam int FILL_W = 9;
	localparam int CAP_W  = 9;

	// capacity after reset, clipped to what the register holds
	localparam int CAP_RST = (DEPTH > 511) ? 511 : DEPTH;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_PEEK   = 3'd2,
		FN_CLEAR  = 3'd3,
		FN_SEARCH = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// one finished result beat
	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  data;
		logic        [IDX_W-1:0]   found_index;
		logic        [FILL_W-1:0]  fill_count;
		logic                      is_empty;
		logic                      is_full;
	} res_t;

	// storage access request from the engine
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== rtl/core/blss_if.sv =====
// ----------------------------------------------------------------------------
// blss channel interfaces
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------

// request channel: operation and operand word
interface blss_req_if;
	import blss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic        [FUNC_W-1:0] func;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

// result channel: one beat per request
interface blss_rsp_if;
	import blss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic        [STAT_W-1:0] status;
	logic signed [WORD_W-1:0] data;
	logic        [IDX_W-1:0]  found_index;
	logic        [FILL_W-1:0] fill_count;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, output status, output data, output found_index,
		output fill_count, output is_empty, output is_full, input ready);
	modport sink   (input valid, input status, input data, input found_index,
		input fill_count, input is_empty, input is_full, output ready);
endinterface

// configuration channel: capacity register write
interface blss_cfg_if;
	import blss_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/core/blss_ram.sv =====
// ----------------------------------------------------------------------------
// blss_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module blss_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 256,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/blss_ctrl.sv =====
// ----------------------------------------------------------------------------
// blss_ctrl
// Stack engine: keeps the fill count, decodes operations, drives the storage
// RAM and walks it top-down for a search, one entry per cycle.
// ----------------------------------------------------------------------------
module blss_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	blss_req_if.sink                 req,
	input  logic [blss_pkg::CNT_W-1:0] lim,
	input  logic                     slot_free,
	output logic                     res_valid,
	output blss_pkg::res_t           res,
	output blss_pkg::ram_req_t       ram,
	input  logic [blss_pkg::WORD_W-1:0] rdata
);
	import blss_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  top_q, top_d;
	logic [CNT_W-1:0]  top_dec;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [WORD_W-1:0] key_q;
	logic              accept;
	logic              hit;
	logic              at_bottom;

	assign top_dec   = top_q - CNT_W'(1);
	assign accept    = req.valid && req.ready;
	assign hit       = (rdata == key_q);
	assign at_bottom = (ptr_q == '0);

	// ready only between operations and with room for the result
	assign req.ready = (state_q == S_IDLE) && slot_free;

	// operation decode and result forming
	always_comb begin
		state_d         = state_q;
		top_d           = top_q;
		ptr_d           = ptr_q;
		res_valid       = 1'b0;
		res.status      = ST_OK;
		res.data        = '0;
		res.found_index = '0;
		ram.we          = 1'b0;
		ram.waddr       = top_q[ADDR_W-1:0];
		ram.wdata       = req.value;
		ram.re          = 1'b0;
		ram.raddr       = top_dec[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.func)
						FN_PUSH: begin
							res_valid = 1'b1;
							if (top_q >= lim) begin
								res.status = ST_FULL;
							end else begin
								ram.we = 1'b1;
								top_d  = top_q + CNT_W'(1);
							end
						end
						FN_POP, FN_PEEK: begin
							if (top_q == '0) begin
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								ram.re  = 1'b1;
								state_d = S_READ;
								if (req.func == FN_POP) begin
									top_d = top_dec;
								end
							end
						end
						FN_CLEAR: begin
							res_valid = 1'b1;
							top_d     = '0;
						end
						FN_SEARCH: begin
							if (top_q == '0) begin
								res_valid  = 1'b1;
								res.status = ST_NOTFOUND;
							end else begin
								ram.re  = 1'b1;
								ptr_d   = top_dec[ADDR_W-1:0];
								state_d = S_SCAN;
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res.data  = $signed(rdata);
				res_valid = slot_free;
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (hit || at_bottom) begin
					res_valid = slot_free;
					if (hit) begin
						res.found_index = IDX_W'(ptr_q);
					end else begin
						res.status = ST_NOTFOUND;
					end
					if (slot_free) begin
						state_d = S_IDLE;
					end
				end else begin
					ram.re    = 1'b1;
					ram.raddr = ptr_q - ADDR_W'(1);
					ptr_d     = ptr_q - ADDR_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res.fill_count = FILL_W'(top_d);
		res.is_empty   = (top_d == '0);
		res.is_full    = (top_d >= lim);
	end

	// state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
		end
	end

	// scan pointer and search key
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (accept) begin
			key_q <= req.value;
		end
	end

	// fill count never passes the storage depth
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// the RAM is never written and read in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram.we && ram.re))
		else $error("storage write and read overlap");

	// a push that is not refused grows the stack by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FN_PUSH && top_q < lim) |=> top_q == $past(top_q) + CNT_W'(1))
		else $error("push did not advance fill count");

	// a result only leaves the engine when the output slot can take it
	a_res_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result without free slot");

	// a scan step only moves the pointer downward
	a_scan_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !hit && !at_bottom) |=> ptr_q == $past(ptr_q) - ADDR_W'(1))
		else $error("scan pointer did not step down");

endmodule

// ===== rtl/core/bounded_lifo_stack_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_search_unit
// Bounded LIFO stack of signed words with a top-down search, a capacity
// register and a one-beat result register toward the sink.
//
//   channel  role    payload                                     handshake
//   req      sink    func, value                                 valid/ready
//   rsp      source  status, data, found_index, fill_count,      valid/ready
//                    is_empty, is_full
//   cfg      sink    capacity                                    valid/ready
//
// push, clear, refusals and unknown codes: result formed in the cycle the request is taken
// pop and peek: result formed from the registered read of the storage RAM
// search: walks entries from the top, at most fill count of them
// reset empties the stack and sets capacity to the storage depth
// a held result blocks new requests; a finished read or scan waits in place
// ----------------------------------------------------------------------------
module bounded_lifo_stack_with_search_unit (
	input  logic       clk,
	input  logic       arst_n,
	blss_req_if.sink   req,
	blss_rsp_if.source rsp,
	blss_cfg_if.sink   cfg
);
	import blss_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  lim;
	logic              slot_free;
	logic              res_valid;
	res_t              res;
	res_t              rsp_q;
	logic              rsp_valid_q;
	ram_req_t          ram;
	logic [WORD_W-1:0] rdata;

	// capacity register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RST);
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity;
		end
	end

	// effective capacity clipped to the storage depth
	assign lim = (int'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

	// result register
	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.data        = rsp_q.data;
	assign rsp.found_index = rsp_q.found_index;
	assign rsp.fill_count  = rsp_q.fill_count;
	assign rsp.is_empty    = rsp_q.is_empty;
	assign rsp.is_full     = rsp_q.is_full;

	// engine
	blss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.lim       (lim),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.ram       (ram),
		.rdata     (rdata)
	);

	// stack storage
	blss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

endmodule
